[rtl/core/hrpd_pkg.sv]
// Shared widths, constants and types for the HSV to RGB PWM duty pipeline.
package hrpd_pkg;

	// pipeline depth, accept to result
	localparam int NUM_STAGES = 7;
	localparam int NUM_CH     = 3;

	// port widths
	localparam int HUE_W   = 16;
	localparam int SAT_W   = 13;
	localparam int BRT_W   = 14;
	localparam int DUTY_W  = 16;
	localparam int FS_W    = 16;
	localparam int CFG_IDX_W = 2;

	// internal widths
	localparam int V_W     = 13;	// clamped value, 0..4096
	localparam int V2_W    = 25;	// value squared, up to 2^24
	localparam int C_W     = 37;	// chroma, up to 2^36
	localparam int H_W     = 15;	// hue after mod 23040
	localparam int FRAC_W  = 12;	// position inside sector, < 3840
	localparam int SECT_W  = 3;
	localparam int NUM_W   = 48;	// channel numerator, up to 3840 * 2^36
	localparam int HALF_W  = 24;
	localparam int PP_W    = HALF_W + FS_W;
	localparam int G_W     = 20;	// numerator * full scale >> 44
	localparam int RECIP_W = 21;

	localparam logic [V_W-1:0]    Q_ONE      = 13'd4096;
	localparam logic [HUE_W-1:0]  HUE_TURN   = 16'd23040;
	localparam logic [HUE_W-1:0]  HUE_TURN2  = 16'd46080;
	localparam logic [H_W-1:0]    HUE_SECTOR = 15'd3840;
	localparam logic [FRAC_W-1:0] SECTOR_LEN = 12'd3840;
	// ceil(2^24 / 15): exact quotient for any dividend below 2^20
	localparam logic [RECIP_W-1:0] RECIP_15  = 21'd1118482;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DUTY_W-1:0] duty_t;

	// what a channel carries inside a hue sector
	typedef enum logic [1:0] {
		ROLE_PRIM,
		ROLE_SEC,
		ROLE_ZERO
	} role_t;

	typedef struct packed {
		role_t r;
		role_t g;
		role_t b;
	} roles_t;

endpackage

[rtl/core/hsv_to_rgb_pwm_duty.sv]
// Top level: HSV to RGB LED PWM compare values, seven-stage pipeline.
//
// Input words (hue, saturation, brightness) enter on in_valid/in_ready; result
// words (red_duty, green_duty, blue_duty) leave on out_valid/out_ready. Hue is
// in 1/64 degree units, saturation and brightness are Q1.12; brightness is
// clamped to [0, 1.0] and squared as a dimming curve.
// An accepted word enters stage 1 and moves through the stages in order to stage
// 7, where it shows on out_valid. Throughput: one word per cycle while out_ready
// does not stall the pipe; stages 1, 2, 3, 5 and 7 each hold one level of
// multipliers (13x13, 25x13, 37x12 per channel, two 24x16 per channel, 20x21).
// Flow control: each stage advances when it is empty or the stage after it
// advances, so bubbles close up and in_ready stays high while the pipe has
// room even with a result parked at the output. When out_ready is low the
// full pipe holds every word in place; nothing is dropped or repeated.
// Full-scale registers are written through cfg_wr_en/cfg_index/cfg_wr_data
// with no wait; index 3 is ignored. They are sampled in stage 5, so write
// them only while the pipe is empty.
// Reset (arst_n low, async): pipe empties, out_valid drops, full-scale
// registers return to 16'hFFFF.
module hsv_to_rgb_pwm_duty (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hrpd_pkg::HUE_W-1:0]      hue,
	input  logic [hrpd_pkg::SAT_W-1:0]      saturation,
	input  logic [hrpd_pkg::BRT_W-1:0]      brightness,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hrpd_pkg::DUTY_W-1:0]     red_duty,
	output logic [hrpd_pkg::DUTY_W-1:0]     green_duty,
	output logic [hrpd_pkg::DUTY_W-1:0]     blue_duty,
	input  logic                            cfg_wr_en,
	input  logic [hrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrpd_pkg::FS_W-1:0]       cfg_wr_data
);
	import hrpd_pkg::*;

	// per-stage valid flags and advance enables
	logic [NUM_STAGES:1] stage_vld_q;
	logic [NUM_STAGES:1] stage_en;

	logic [NUM_CH-1:0][FS_W-1:0]  full_scale_q;

	logic [C_W-1:0]       c_s2;
	logic [V2_W-1:0]      v2_s2;
	logic [SECT_W-1:0]    sect_s2;
	logic [FRAC_W-1:0]    frac_s2;
	logic [NUM_CH-1:0][NUM_W-1:0]  f_s4;
	logic [NUM_CH-1:0][DUTY_W-1:0] duty_s7;

	// a stage may load when empty or when its successor moves on
	always_comb begin
		stage_en[NUM_STAGES] = !stage_vld_q[NUM_STAGES] || out_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				stage_vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = stage_en[1];
	assign out_valid = stage_vld_q[NUM_STAGES];

	// full-scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= '1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RED:   full_scale_q[0] <= cfg_wr_data;
				REG_GREEN: full_scale_q[1] <= cfg_wr_data;
				REG_BLUE:  full_scale_q[2] <= cfg_wr_data;
				default:   ;
			endcase
		end
	end

	hrpd_front u_front (
		.clk        (clk),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.en_s1      (stage_en[1]),
		.en_s2      (stage_en[2]),
		.c_s2       (c_s2),
		.v2_s2      (v2_s2),
		.sect_s2    (sect_s2),
		.frac_s2    (frac_s2)
	);

	hrpd_mix u_mix (
		.clk     (clk),
		.c_s2    (c_s2),
		.v2_s2   (v2_s2),
		.sect_s2 (sect_s2),
		.frac_s2 (frac_s2),
		.en_s3   (stage_en[3]),
		.en_s4   (stage_en[4]),
		.f_s4    (f_s4)
	);

	// one scaler per color channel
	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_scale
		hrpd_scale u_scale (
			.clk        (clk),
			.f_s4       (f_s4[ch]),
			.full_scale (full_scale_q[ch]),
			.en_s5      (stage_en[5]),
			.en_s6      (stage_en[6]),
			.en_s7      (stage_en[7]),
			.duty_s7    (duty_s7[ch])
		);
	end

	assign red_duty   = duty_s7[0];
	assign green_duty = duty_s7[1];
	assign blue_duty  = duty_s7[2];

endmodule

[rtl/core/hrpd_front.sv]
// Stages 1-2: clamp, dimming square, hue reduction, sector split, chroma.
module hrpd_front (
	input  logic                        clk,
	input  logic [hrpd_pkg::HUE_W-1:0]  hue,
	input  logic [hrpd_pkg::SAT_W-1:0]  saturation,
	input  logic [hrpd_pkg::BRT_W-1:0]  brightness,
	input  logic                        en_s1,
	input  logic                        en_s2,
	output logic [hrpd_pkg::C_W-1:0]    c_s2,
	output logic [hrpd_pkg::V2_W-1:0]   v2_s2,
	output logic [hrpd_pkg::SECT_W-1:0] sect_s2,
	output logic [hrpd_pkg::FRAC_W-1:0] frac_s2
);
	import hrpd_pkg::*;

	logic [V_W-1:0]      v_cl;
	logic [SAT_W-1:0]    sat_cl;
	logic [HUE_W-1:0]    hue_red;
	logic [2*V_W-1:0]    vsq;
	logic [V2_W-1:0]     v2_s1;
	logic [SAT_W-1:0]    sat_s1;
	logic [H_W-1:0]      h_s1;
	logic [SECT_W-1:0]   sect;
	logic [H_W-1:0]      sect_base;
	logic [H_W-1:0]      h_off;
	logic [V2_W+SAT_W-1:0] cprod;

	// stage 1
	always_comb begin
		if (brightness[BRT_W-1]) begin
			v_cl = '0;
		end else if (brightness[V_W-1:0] > Q_ONE) begin
			v_cl = Q_ONE;
		end else begin
			v_cl = brightness[V_W-1:0];
		end
		sat_cl = (saturation > Q_ONE) ? Q_ONE : saturation;
		if (hue >= HUE_TURN2) begin
			hue_red = hue - HUE_TURN2;
		end else if (hue >= HUE_TURN) begin
			hue_red = hue - HUE_TURN;
		end else begin
			hue_red = hue;
		end
		vsq = v_cl * v_cl;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			v2_s1  <= vsq[V2_W-1:0];
			sat_s1 <= sat_cl;
			h_s1   <= hue_red[H_W-1:0];
		end
	end

	// stage 2
	always_comb begin
		sect      = '0;
		sect_base = '0;
		for (int k = 1; k < 6; k++) begin
			if (h_s1 >= H_W'(k * 3840)) begin
				sect      = SECT_W'(k);
				sect_base = H_W'(k * 3840);
			end
		end
		h_off = h_s1 - sect_base;
		cprod = v2_s1 * sat_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			c_s2    <= cprod[C_W-1:0];
			v2_s2   <= v2_s1;
			sect_s2 <= sect;
			frac_s2 <= h_off[FRAC_W-1:0];
		end
	end

endmodule

[rtl/core/hrpd_mix.sv]
// Stages 3-4: per-channel sector mix, numerator = V2*4096*3840 - C*a.
module hrpd_mix (
	input  logic                                        clk,
	input  logic [hrpd_pkg::C_W-1:0]                    c_s2,
	input  logic [hrpd_pkg::V2_W-1:0]                   v2_s2,
	input  logic [hrpd_pkg::SECT_W-1:0]                 sect_s2,
	input  logic [hrpd_pkg::FRAC_W-1:0]                 frac_s2,
	input  logic                                        en_s3,
	input  logic                                        en_s4,
	output logic [hrpd_pkg::NUM_CH-1:0][hrpd_pkg::NUM_W-1:0] f_s4
);
	import hrpd_pkg::*;

	roles_t                          roles;
	role_t  [NUM_CH-1:0]             role_v;
	logic   [FRAC_W-1:0]             sec_a;
	logic   [NUM_CH-1:0][FRAC_W-1:0] a;
	logic   [NUM_CH-1:0][C_W+FRAC_W-1:0] prod;
	logic   [V2_W+3:0]               v15;
	num_t                            base_s3;
	num_t   [NUM_CH-1:0]             p_s3;

	// roles per sector; out-of-range sectors never occur and fall to sector 5
	always_comb begin
		case (sect_s2)
			3'd0:    roles = '{r: ROLE_PRIM, g: ROLE_SEC,  b: ROLE_ZERO};
			3'd1:    roles = '{r: ROLE_SEC,  g: ROLE_PRIM, b: ROLE_ZERO};
			3'd2:    roles = '{r: ROLE_ZERO, g: ROLE_PRIM, b: ROLE_SEC};
			3'd3:    roles = '{r: ROLE_ZERO, g: ROLE_SEC,  b: ROLE_PRIM};
			3'd4:    roles = '{r: ROLE_SEC,  g: ROLE_ZERO, b: ROLE_PRIM};
			default: roles = '{r: ROLE_PRIM, g: ROLE_ZERO, b: ROLE_SEC};
		endcase
		role_v[0] = roles.r;
		role_v[1] = roles.g;
		role_v[2] = roles.b;

		// a = 3840 - x, x = t*3840 in even sectors, (1-t)*3840 in odd
		sec_a = sect_s2[0] ? frac_s2 : (SECTOR_LEN - frac_s2);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case (role_v[ch])
				ROLE_PRIM: a[ch] = '0;
				ROLE_SEC:  a[ch] = sec_a;
				default:   a[ch] = SECTOR_LEN;
			endcase
			prod[ch] = c_s2 * a[ch];
		end
		v15 = v2_s2 * 4'd15;
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (en_s3) begin
			base_s3 <= {v15[27:0], 20'd0};
			for (int ch = 0; ch < NUM_CH; ch++) begin
				p_s3[ch] <= prod[ch][NUM_W-1:0];
			end
		end
	end

	// stage 4: never negative, C*a <= V2*4096*3840
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				f_s4[ch] <= base_s3 - p_s3[ch];
			end
		end
	end

endmodule

[rtl/core/hrpd_scale.sv]
// Stages 5-7: one channel, duty = floor(num * full / (2^44 * 15)).
module hrpd_scale (
	input  logic                         clk,
	input  logic [hrpd_pkg::NUM_W-1:0]   f_s4,
	input  logic [hrpd_pkg::FS_W-1:0]    full_scale,
	input  logic                         en_s5,
	input  logic                         en_s6,
	input  logic                         en_s7,
	output logic [hrpd_pkg::DUTY_W-1:0]  duty_s7
);
	import hrpd_pkg::*;

	logic [PP_W-1:0]          lo_s5;
	logic [PP_W-1:0]          hi_s5;
	logic [63:0]              sum;
	logic [G_W-1:0]           g_s6;
	logic [G_W+RECIP_W-1:0]   qprod;

	// stage 5: 48x16 split into two 24x16 partial products
	always_ff @(posedge clk) begin
		if (en_s5) begin
			lo_s5 <= f_s4[HALF_W-1:0] * full_scale;
			hi_s5 <= f_s4[NUM_W-1:HALF_W] * full_scale;
		end
	end

	// stage 6: recombine, drop 2^44
	always_comb begin
		sum   = {hi_s5, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, lo_s5};
		qprod = g_s6 * RECIP_15;
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			g_s6 <= sum[63:44];
		end
	end

	// stage 7: divide by 15 through reciprocal
	always_ff @(posedge clk) begin
		if (en_s7) begin
			duty_s7 <= qprod[24 +: DUTY_W];
		end
	end

endmodule
